// File: rtl/dcrc_pkg.sv
// Shared types, constants and the CRC byte update for the dual copy record check.
`timescale 1ns / 1ps
package dcrc_pkg;

  localparam int MaxRecordBytes = 64;
  localparam int RecordBytesW   = 7;
  localparam logic [RecordBytesW-1:0] RecordBytesRst = 7'd24;
  localparam int MinRecordBytes = 3;

  localparam logic [15:0] CrcPoly = 16'h8005;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  typedef enum logic [1:0] {
    ChoiceBoth   = 2'd0,
    ChoiceFirst  = 2'd1,
    ChoiceSecond = 2'd2,
    ChoiceNone   = 2'd3
  } choice_e;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] choice;
    logic       first_good;
    logic       second_good;
  } out_beat_t;

  typedef struct packed {
    logic [RecordBytesW-1:0] record_bytes;
  } cfg_beat_t;

  typedef struct packed {
    logic      fire;
    out_beat_t beat;
  } core_res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/dcrc_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
`timescale 1ns / 1ps
interface dcrc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dcrc_core.sv
// Record checker state: CRC accumulation, stored CRC capture and copy verdict.
`timescale 1ns / 1ps
module dcrc_core import dcrc_pkg::*; #(
  parameter int MAX_RECORD_BYTES = MaxRecordBytes
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              byte_i,
  input  logic [RecordBytesW-1:0] record_bytes_i,
  output core_res_t               res_o
);

  localparam int PosW  = $clog2(MAX_RECORD_BYTES);
  localparam int MaxLw = $clog2(MAX_RECORD_BYTES + 1);
  localparam int LenW  = ((RecordBytesW > MaxLw) ? RecordBytesW : MaxLw) + 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_RECORD_BYTES);
  localparam logic [LenW-1:0] MinLen = LenW'(MinRecordBytes);

  logic [15:0]     crc_q, crc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            copy_q, copy_d;
  logic [7:0]      low_q, low_d;
  logic            first_ok_q, first_ok_d;

  logic [LenW-1:0] rb_ext, len, pos_two;
  logic            is_body, is_low, ok;
  choice_e         choice;

  always_comb begin
    rb_ext = LenW'(record_bytes_i);
    priority if (rb_ext < MinLen) begin
      len = MinLen;
    end else if (rb_ext > MaxLen) begin
      len = MaxLen;
    end else begin
      len = rb_ext;
    end
    pos_two = LenW'(pos_q) + LenW'(2);
    is_body = pos_two < len;
    is_low  = pos_two == len;
    ok      = crc_q == {byte_i, low_q};

    priority if (first_ok_q && ok) begin
      choice = ChoiceBoth;
    end else if (first_ok_q) begin
      choice = ChoiceFirst;
    end else if (ok) begin
      choice = ChoiceSecond;
    end else begin
      choice = ChoiceNone;
    end

    crc_d      = crc_q;
    pos_d      = pos_q;
    copy_d     = copy_q;
    low_d      = low_q;
    first_ok_d = first_ok_q;
    if (step_i) begin
      priority if (is_body) begin
        crc_d = crc_byte(crc_q, byte_i);
        pos_d = pos_q + PosW'(1);
      end else if (is_low) begin
        low_d = byte_i;
        pos_d = pos_q + PosW'(1);
      end else begin
        crc_d = CrcInit;
        pos_d = '0;
        low_d = '0;
        if (!copy_q) begin
          first_ok_d = ok;
          copy_d     = 1'b1;
        end else begin
          first_ok_d = 1'b0;
          copy_d     = 1'b0;
        end
      end
    end

    // flag a byte that ends the pair, whether or not it steps this cycle
    res_o.fire             = !is_body && !is_low && copy_q;
    res_o.beat.choice      = choice;
    res_o.beat.first_good  = first_ok_q;
    res_o.beat.second_good = ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CrcInit;
      pos_q      <= '0;
      copy_q     <= 1'b0;
      low_q      <= '0;
      first_ok_q <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      pos_q      <= pos_d;
      copy_q     <= copy_d;
      low_q      <= low_d;
      first_ok_q <= first_ok_d;
    end
  end

endmodule

// File: rtl/dual_copy_record_crc_check_unit.sv
// Top level: input register, record checker and result register.
// Path: an accepted byte is held in the input register and then steps the check state;
// the verdict of a pair is captured in the result register and driven on out_o.
// Throughput: one byte per cycle, limited only by the result register when full.
// Reset: CRC to 0xFFFF, position and copy to the start of a pair, length to 24.
`timescale 1ns / 1ps
module dual_copy_record_crc_check_unit import dcrc_pkg::*; #(
  parameter int MAX_RECORD_BYTES = MaxRecordBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dcrc_chan_if.sink     in_i,
  dcrc_chan_if.sink     cfg_i,
  dcrc_chan_if.source   out_o
);

  logic                    in_vld_q;
  logic [7:0]              in_byte_q;
  logic                    out_vld_q;
  out_beat_t               out_beat_q;
  logic [RecordBytesW-1:0] record_bytes_q;
  logic                    advance;
  core_res_t               res;
  in_beat_t                in_beat;
  cfg_beat_t               cfg_beat;

  assign in_beat  = in_i.data;
  assign cfg_beat = cfg_i.data;

  // advance the held beat unless it carries a verdict and the result slot is blocked
  assign advance     = in_vld_q && (!out_vld_q || out_o.ready || !res.fire);
  assign in_i.ready  = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_beat_q;

  dcrc_core #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .record_bytes_i(record_bytes_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      record_bytes_q <= RecordBytesRst;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance && res.fire) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        record_bytes_q <= cfg_beat.record_bytes;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_beat.data_byte;
    end
    if (advance && res.fire) begin
      out_beat_q <= res.beat;
    end
  end

endmodule

// File: verif/tb_dual_copy_record_crc_check_unit.sv
// Self-checking testbench for the dual copy record CRC check unit.
`timescale 1ns / 1ps
import dcrc_pkg::*;

class record_pair_scoreboard;
  logic [RecordBytesW-1:0] length_reg;
  logic [15:0] crc_acc;
  logic [5:0] byte_idx;
  bit on_second;
  logic [7:0] held_low;
  bit first_ok;
  out_beat_t verdict_q[$];
  int unsigned errors;

  function new();
    length_reg = RecordBytesRst;
    crc_acc = CrcInit;
    byte_idx = '0;
    on_second = 1'b0;
    held_low = '0;
    first_ok = 1'b0;
    errors = 0;
  endfunction

  function int unsigned copy_len();
    if (length_reg < MinRecordBytes) return MinRecordBytes;
    if (length_reg > MaxRecordBytes) return MaxRecordBytes;
    return length_reg;
  endfunction

  function logic [15:0] advance_crc(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  function void note_byte(logic [7:0] b);
    int unsigned n;
    bit ok;
    out_beat_t v;
    n = copy_len();
    if (byte_idx + 2 < n) begin
      crc_acc = advance_crc(crc_acc, b);
      byte_idx++;
    end else if (byte_idx + 2 == n) begin
      held_low = b;
      byte_idx++;
    end else begin
      ok = (crc_acc == {b, held_low});
      crc_acc = CrcInit;
      byte_idx = '0;
      held_low = '0;
      if (!on_second) begin
        first_ok = ok;
        on_second = 1'b1;
      end else begin
        if (first_ok && ok) v.choice = ChoiceBoth;
        else if (first_ok) v.choice = ChoiceFirst;
        else if (ok) v.choice = ChoiceSecond;
        else v.choice = ChoiceNone;
        v.first_good = first_ok;
        v.second_good = ok;
        verdict_q.push_back(v);
        on_second = 1'b0;
        first_ok = 1'b0;
      end
    end
  endfunction

  function void check_verdict(out_beat_t got);
    out_beat_t want;
    if (verdict_q.size() == 0) begin
      $error("unexpected verdict beat: choice %0d first_good %0b second_good %0b",
             got.choice, got.first_good, got.second_good);
      errors++;
      return;
    end
    want = verdict_q.pop_front();
    if (got.choice !== want.choice) begin
      $error("choice: expected %0d, actual %0d", want.choice, got.choice);
      errors++;
    end
    if (got.first_good !== want.first_good) begin
      $error("first_good: expected %0b, actual %0b", want.first_good, got.first_good);
      errors++;
    end
    if (got.second_good !== want.second_good) begin
      $error("second_good: expected %0b, actual %0b", want.second_good, got.second_good);
      errors++;
    end
  endfunction
endclass

module tb_dual_copy_record_crc_check_unit;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TargetBytes = 1400;

  logic clk;
  logic rst_n;
  int unsigned cycles = 0;
  int unsigned bytes_sent;
  bit src_burst;
  bit snk_burst;
  bit hold_req;
  record_pair_scoreboard sb;

  logic [RecordBytesW-1:0] edge_len [8] = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd2, 7'd65, 7'd24, 7'd3};

  dcrc_chan_if #(.payload_t(in_beat_t))  in_if ();
  dcrc_chan_if #(.payload_t(cfg_beat_t)) cfg_if ();
  dcrc_chan_if #(.payload_t(out_beat_t)) out_if ();

  dual_copy_record_crc_check_unit uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_verdict(out_if.data);
  end

  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap(src_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{data_byte: b};
    do @(posedge clk); while (!in_if.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // finish the current copy from wherever the stream stands, CRC bytes from the running sum
  task automatic send_copy(input bit good, input bit fixed, input logic [7:0] fill);
    bit done;
    bit low_sent;
    bit hit_high;
    logic [7:0] flip;
    logic [7:0] b;
    done = 1'b0;
    low_sent = 1'b0;
    hit_high = $urandom_range(0, 1);
    flip = good ? 8'h00 : (8'h01 << $urandom_range(0, 7));
    while (!done) begin
      if (sb.byte_idx + 2 < sb.copy_len()) begin
        b = fixed ? fill : 8'($urandom_range(0, 255));
      end else if (sb.byte_idx + 2 == sb.copy_len()) begin
        b = sb.crc_acc[7:0] ^ (hit_high ? 8'h00 : flip);
        low_sent = 1'b1;
      end else begin
        b = sb.crc_acc[15:8] ^ ((hit_high || !low_sent) ? flip : 8'h00);
        done = 1'b1;
      end
      send_byte(b);
    end
  endtask

  task automatic write_length(input logic [RecordBytesW-1:0] v);
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{record_bytes: v};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.length_reg = v;
  endtask

  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        int unsigned g;
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        g = pick_gap(snk_burst);
        if (g > 0) begin
          out_if.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned pairs;
    int unsigned r;
    logic [RecordBytesW-1:0] v;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    bytes_sent = 0;
    src_burst = 1'b0;
    snk_burst = 1'b0;
    hold_req = 1'b0;
    sb = new();
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    write_length(7'd3);
    send_copy(1'b1, 1'b1, 8'h00);
    send_copy(1'b1, 1'b1, 8'h00);
    send_copy(1'b1, 1'b1, 8'hFF);
    send_copy(1'b0, 1'b1, 8'hFF);
    send_copy(1'b0, 1'b1, 8'h00);
    send_copy(1'b1, 1'b1, 8'h00);
    send_copy(1'b0, 1'b1, 8'hFF);
    send_copy(1'b0, 1'b1, 8'hFF);
    in_if.valid <= 1'b0;

    ph = 0;
    while (bytes_sent < TargetBytes) begin
      if (ph < 8) begin
        v = edge_len[ph];
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) v = 7'($urandom_range(3, 10));
        else if (r < 90) v = 7'($urandom_range(11, 40));
        else v = 7'($urandom_range(0, 127));
      end
      write_length(v);
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      if (ph == 0) begin
        hold_req = 1'b1;
        pairs = 40;
      end else begin
        pairs = (sb.copy_len() <= 16) ? $urandom_range(3, 10) : $urandom_range(1, 2);
      end
      repeat (pairs) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        send_copy($urandom_range(0, 3) != 0, 1'b0, 8'h00);
        send_copy($urandom_range(0, 3) != 0, 1'b0, 8'h00);
      end
      // leave a pair part sent so the next length lands mid-pair
      if (ph == 2) begin
        repeat (40) send_byte(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 2 * sb.copy_len() - 1)) send_byte(8'($urandom_range(0, 255)));
      end
      in_if.valid <= 1'b0;
      ph++;
    end

    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: dual_copy_record_crc_check_unit.f
rtl/dcrc_pkg.sv
rtl/dcrc_chan_if.sv
rtl/dcrc_core.sv
rtl/dual_copy_record_crc_check_unit.sv
verif/tb_dual_copy_record_crc_check_unit.sv
